FILE: hdl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants for the thermostat and defrost controller.
// ----------------------------------------------------------------------------
package tdc_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COOLING = 2'd1,
      MODE_WAITING = 2'd2,
      MODE_DEFROST = 2'd3
   } mode_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FORCE  = 1'b1;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_SETPOINT   = 3'd0;
   localparam logic [2:0] REG_HYSTERESIS = 3'd1;
   localparam logic [2:0] REG_INTERVAL   = 3'd2;
   localparam logic [2:0] REG_START_TH   = 3'd3;
   localparam logic [2:0] REG_STOP_TEMP  = 3'd4;
   localparam logic [2:0] REG_MAX_TIME   = 3'd5;

   localparam logic [8:0]  HYST_MIN = 9'd10;
   localparam logic [8:0]  HYST_MAX = 9'd500;

   localparam logic [15:0] RST_SETPOINT   = 16'h0000;
   localparam logic [8:0]  RST_HYSTERESIS = 9'd200;
   localparam logic [19:0] RST_INTERVAL   = 20'd86400;
   localparam logic [15:0] RST_START_TH   = 16'hFB50;  // -12.00 C
   localparam logic [15:0] RST_STOP_TEMP  = 16'h0000;
   localparam logic [11:0] RST_MAX_TIME   = 12'd300;

   typedef struct packed {
      logic [15:0] setpoint;
      logic [8:0]  hysteresis;
      logic [19:0] defrost_interval_seconds;
      logic [15:0] defrost_start_threshold;
      logic [15:0] defrost_stop_temperature;
      logic [11:0] defrost_max_seconds;
   } cfg_type;

   typedef struct packed {
      logic        command;
      logic [31:0] now_seconds;
      logic [15:0] probe_one_temp;
      logic [15:0] probe_two_temp;
      logic        probe_one_valid;
      logic        probe_two_valid;
   } item_type;

   typedef struct packed {
      logic        compressor_drive;
      logic        heater_drive;
      logic [1:0]  mode;
      logic        update_ok;
      logic [19:0] seconds_to_defrost;
      logic [31:0] cooling_count;
      logic [31:0] defrost_count;
      logic [31:0] defrost_cut_count;
   } result_type;

endpackage

FILE: hdl/tdc_csr.sv
// ----------------------------------------------------------------------------
// tdc_csr
// Configuration registers behind the bus port, hysteresis clamped on write.
// ----------------------------------------------------------------------------
module tdc_csr
   import tdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;
   logic [8:0] hyst_wr;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      hyst_wr = pwdata[8:0];
      if (hyst_wr < HYST_MIN) begin
         hyst_wr = HYST_MIN;
      end else if (hyst_wr > HYST_MAX) begin
         hyst_wr = HYST_MAX;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SETPOINT:   cfg_in.setpoint                 = pwdata[15:0];
            REG_HYSTERESIS: cfg_in.hysteresis               = hyst_wr;
            REG_INTERVAL:   cfg_in.defrost_interval_seconds = pwdata[19:0];
            REG_START_TH:   cfg_in.defrost_start_threshold  = pwdata[15:0];
            REG_STOP_TEMP:  cfg_in.defrost_stop_temperature = pwdata[15:0];
            REG_MAX_TIME:   cfg_in.defrost_max_seconds      = pwdata[11:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint                 <= RST_SETPOINT;
         cfg_ff.hysteresis               <= RST_HYSTERESIS;
         cfg_ff.defrost_interval_seconds <= RST_INTERVAL;
         cfg_ff.defrost_start_threshold  <= RST_START_TH;
         cfg_ff.defrost_stop_temperature <= RST_STOP_TEMP;
         cfg_ff.defrost_max_seconds      <= RST_MAX_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // signed registers read back sign extended
   always_comb begin
      case (reg_idx)
         REG_SETPOINT:   prdata = {{16{cfg_ff.setpoint[15]}}, cfg_ff.setpoint};
         REG_HYSTERESIS: prdata = {23'd0, cfg_ff.hysteresis};
         REG_INTERVAL:   prdata = {12'd0, cfg_ff.defrost_interval_seconds};
         REG_START_TH:   prdata = {{16{cfg_ff.defrost_start_threshold[15]}},
                                   cfg_ff.defrost_start_threshold};
         REG_STOP_TEMP:  prdata = {{16{cfg_ff.defrost_stop_temperature[15]}},
                                   cfg_ff.defrost_stop_temperature};
         REG_MAX_TIME:   prdata = {20'd0, cfg_ff.defrost_max_seconds};
         default:        prdata = 32'd0;
      endcase
   end

endmodule

FILE: hdl/tdc_core.sv
// ----------------------------------------------------------------------------
// tdc_core
// Controller state and the combinational update for one item.
// ----------------------------------------------------------------------------
module tdc_core
   import tdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   mode_type    mode_ff, mode_in;
   logic        comp_ff, comp_in;
   logic        heater_ff, heater_in;
   logic        due_ff, due_in;
   logic [31:0] last_stamp_ff, last_stamp_in;
   logic [31:0] begin_stamp_ff, begin_stamp_in;
   logic [31:0] cooling_cnt_ff, cooling_cnt_in;
   logic [31:0] defrost_cnt_ff, defrost_cnt_in;
   logic [31:0] cut_cnt_ff, cut_cnt_in;

   logic [31:0]        interval32;
   logic [31:0]        elapsed;
   logic [31:0]        run_time;
   logic signed [17:0] t1_ext;
   logic signed [17:0] sp_ext;
   logic signed [17:0] upper;
   logic signed [15:0] t2_s;
   logic               ok;
   logic               stamp_now;
   logic [19:0]        left;

   assign interval32 = {12'd0, cfg.defrost_interval_seconds};
   assign elapsed    = item.now_seconds - last_stamp_ff;
   assign run_time   = item.now_seconds - begin_stamp_ff;
   assign t1_ext     = $signed({{2{item.probe_one_temp[15]}}, item.probe_one_temp});
   assign sp_ext     = $signed({{2{cfg.setpoint[15]}}, cfg.setpoint});
   assign upper      = sp_ext + $signed({9'd0, cfg.hysteresis});
   assign t2_s       = $signed(item.probe_two_temp);

   always_comb begin
      mode_in        = mode_ff;
      comp_in        = comp_ff;
      heater_in      = heater_ff;
      due_in         = due_ff;
      last_stamp_in  = last_stamp_ff;
      begin_stamp_in = begin_stamp_ff;
      cooling_cnt_in = cooling_cnt_ff;
      defrost_cnt_in = defrost_cnt_ff;
      cut_cnt_in     = cut_cnt_ff;
      ok             = 1'b1;
      stamp_now      = 1'b0;
      if (item.command == CMD_FORCE) begin
         due_in        = 1'b1;
         last_stamp_in = item.now_seconds - interval32;
      end else begin
         if (elapsed >= interval32) begin
            due_in = 1'b1;
         end
         if (mode_ff == MODE_DEFROST) begin
            if (item.probe_two_valid &&
                t2_s >= $signed(cfg.defrost_stop_temperature)) begin
               mode_in       = MODE_IDLE;
               heater_in     = 1'b0;
               due_in        = 1'b0;
               last_stamp_in = item.now_seconds;
               stamp_now     = 1'b1;
               cut_cnt_in    = cut_cnt_ff + 32'd1;
            end else if (run_time >= {20'd0, cfg.defrost_max_seconds}) begin
               mode_in       = MODE_IDLE;
               heater_in     = 1'b0;
               due_in        = 1'b0;
               last_stamp_in = item.now_seconds;
               stamp_now     = 1'b1;
            end
         end else if (due_in && item.probe_two_valid &&
                      t2_s <= $signed(cfg.defrost_start_threshold)) begin
            mode_in        = MODE_DEFROST;
            heater_in      = 1'b1;
            comp_in        = 1'b0;
            begin_stamp_in = item.now_seconds;
            defrost_cnt_in = defrost_cnt_ff + 32'd1;
         end else begin
            // evaporator too warm: skip this defrost and restart the interval
            if (due_in && item.probe_two_valid) begin
               due_in        = 1'b0;
               last_stamp_in = item.now_seconds;
               stamp_now     = 1'b1;
            end
            if (!item.probe_one_valid) begin
               ok = 1'b0;
               if (comp_ff) begin
                  comp_in = 1'b0;
                  mode_in = MODE_IDLE;
               end
            end else if (t1_ext > upper) begin
               if (!comp_ff) begin
                  comp_in        = 1'b1;
                  mode_in        = MODE_COOLING;
                  cooling_cnt_in = cooling_cnt_ff + 32'd1;
               end
            end else if ($signed(item.probe_one_temp) < $signed(cfg.setpoint)) begin
               if (comp_ff) begin
                  comp_in = 1'b0;
                  mode_in = MODE_WAITING;
               end
            end
         end
      end
   end

   // elapsed after the update is the full interval on force, zero when restamped
   always_comb begin
      if (item.command == CMD_FORCE) begin
         left = 20'd0;
      end else if (stamp_now) begin
         left = cfg.defrost_interval_seconds;
      end else if (elapsed >= interval32) begin
         left = 20'd0;
      end else begin
         left = cfg.defrost_interval_seconds - elapsed[19:0];
      end
   end

   always_comb begin
      result.compressor_drive   = (mode_in == MODE_DEFROST) ? 1'b0 : comp_in;
      result.heater_drive       = heater_in;
      result.mode               = mode_in;
      result.update_ok          = ok;
      result.seconds_to_defrost = left;
      result.cooling_count      = cooling_cnt_in;
      result.defrost_count      = defrost_cnt_in;
      result.defrost_cut_count  = cut_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         comp_ff        <= 1'b0;
         heater_ff      <= 1'b0;
         due_ff         <= 1'b0;
         last_stamp_ff  <= 32'd0;
         begin_stamp_ff <= 32'd0;
         cooling_cnt_ff <= 32'd0;
         defrost_cnt_ff <= 32'd0;
         cut_cnt_ff     <= 32'd0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         comp_ff        <= comp_in;
         heater_ff      <= heater_in;
         due_ff         <= due_in;
         last_stamp_ff  <= last_stamp_in;
         begin_stamp_ff <= begin_stamp_in;
         cooling_cnt_ff <= cooling_cnt_in;
         defrost_cnt_ff <= defrost_cnt_in;
         cut_cnt_ff     <= cut_cnt_in;
      end
   end

   a_heater_means_defrost: assert property (@(posedge clock) disable iff (reset)
      heater_ff == (mode_ff == MODE_DEFROST))
      else $error("heater state disagrees with defrost mode");

   a_comp_means_cooling: assert property (@(posedge clock) disable iff (reset)
      comp_ff == (mode_ff == MODE_COOLING))
      else $error("compressor state disagrees with cooling mode");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(cooling_cnt_ff) && $stable(defrost_cnt_ff) &&
                    $stable(cut_cnt_ff)))
      else $error("counter moved without an item");

   a_defrost_start_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && mode_ff != MODE_DEFROST && mode_in == MODE_DEFROST)
      |=> defrost_cnt_ff == $past(defrost_cnt_ff) + 32'd1)
      else $error("defrost start not counted");

endmodule

FILE: hdl/thermostat_defrost_controller.sv
// ----------------------------------------------------------------------------
// thermostat_defrost_controller
// Refrigeration thermostat with hysteresis and a timed heater defrost cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a probe sample (command 0) or a force-defrost
//   request (command 1). rsp_* returns exactly one result per item: drive
//   outputs, mode, seconds to the next defrost and three wrapping counters.
//   Both channels use valid/ready. The configuration registers sit behind
//   the psel/penable bus at byte address 4 * index; the user must write them
//   only while no item is in flight, as the block does not enforce it.
//   An accepted item is held in the input register, and the state update
//   writes the result register once that register is free or draining. One
//   item per cycle is sustained while rsp_ready stays high; the state update
//   is a single compare/subtract pass, so an item sees the state left by the
//   one before it.
//   While rsp_ready is low a finished result waits in the output register;
//   one more item is still taken into the input register, then req_ready
//   drops until the result leaves.
//   Reset clears the controller state, counters and registers to defaults.
// ----------------------------------------------------------------------------
module thermostat_defrost_controller
   import tdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_now_seconds,
   input  logic signed [15:0] req_probe_one_temp,
   input  logic signed [15:0] req_probe_two_temp,
   input  logic        req_probe_one_valid,
   input  logic        req_probe_two_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_compressor_drive,
   output logic        rsp_heater_drive,
   output logic [1:0]  rsp_mode,
   output logic        rsp_update_ok,
   output logic [19:0] rsp_seconds_to_defrost,
   output logic [31:0] rsp_cooling_count,
   output logic [31:0] rsp_defrost_count,
   output logic [31:0] rsp_defrost_cut_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       take;

   tdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // item moves into the result register when that register is free or draining
   assign advance   = item_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~item_valid_ff | advance;
   assign take      = req_valid & req_ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.command         <= req_command;
         item_ff.now_seconds     <= req_now_seconds;
         item_ff.probe_one_temp  <= req_probe_one_temp;
         item_ff.probe_two_temp  <= req_probe_two_temp;
         item_ff.probe_one_valid <= req_probe_one_valid;
         item_ff.probe_two_valid <= req_probe_two_valid;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   tdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_compressor_drive   = result_ff.compressor_drive;
   assign rsp_heater_drive       = result_ff.heater_drive;
   assign rsp_mode               = result_ff.mode;
   assign rsp_update_ok          = result_ff.update_ok;
   assign rsp_seconds_to_defrost = result_ff.seconds_to_defrost;
   assign rsp_cooling_count      = result_ff.cooling_count;
   assign rsp_defrost_count      = result_ff.defrost_count;
   assign rsp_defrost_cut_count  = result_ff.defrost_cut_count;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermostat and defrost controller: queued items
// are driven under random idling, each accepted item is run through an
// in-bench controller model, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import tdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_SAMPLE;
   logic [31:0] req_now_seconds = '0;
   logic signed [15:0] req_probe_one_temp = '0;
   logic signed [15:0] req_probe_two_temp = '0;
   logic        req_probe_one_valid = 1'b0;
   logic        req_probe_two_valid = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_compressor_drive;
   logic        rsp_heater_drive;
   logic [1:0]  rsp_mode;
   logic        rsp_update_ok;
   logic [19:0] rsp_seconds_to_defrost;
   logic [31:0] rsp_cooling_count;
   logic [31:0] rsp_defrost_count;
   logic [31:0] rsp_defrost_cut_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   thermostat_defrost_controller u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_now_seconds        (req_now_seconds),
      .req_probe_one_temp     (req_probe_one_temp),
      .req_probe_two_temp     (req_probe_two_temp),
      .req_probe_one_valid    (req_probe_one_valid),
      .req_probe_two_valid    (req_probe_two_valid),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_compressor_drive   (rsp_compressor_drive),
      .rsp_heater_drive       (rsp_heater_drive),
      .rsp_mode               (rsp_mode),
      .rsp_update_ok          (rsp_update_ok),
      .rsp_seconds_to_defrost (rsp_seconds_to_defrost),
      .rsp_cooling_count      (rsp_cooling_count),
      .rsp_defrost_count      (rsp_defrost_count),
      .rsp_defrost_cut_count  (rsp_defrost_cut_count),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always #5 clock = ~clock;

   // configuration as the controller should hold it
   int          cfg_setpoint   = 0;
   int          cfg_hysteresis = 200;
   logic [19:0] cfg_interval   = 20'd86400;
   int          cfg_start_th   = -1200;
   int          cfg_stop_temp  = 0;
   logic [11:0] cfg_max_time   = 12'd300;

   // controller state
   mode_type    ctl_mode = MODE_IDLE;
   logic        comp_on = 1'b0;
   logic        heat_active = 1'b0;
   logic        defrost_pending = 1'b0;
   logic [31:0] last_defrost_at = '0;
   logic [31:0] defrost_began_at = '0;
   logic [31:0] cooling_starts = '0;
   logic [31:0] defrost_starts = '0;
   logic [31:0] defrost_cuts = '0;

   item_type    pending_items[$];
   result_type  expected_readouts[$];
   item_type    offered_item;
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic [31:0] sim_now = '0;

   function automatic void close_defrost(logic [31:0] now);
      ctl_mode = MODE_IDLE;
      heat_active = 1'b0;
      defrost_pending = 1'b0;
      last_defrost_at = now;
   endfunction

   function automatic result_type step_thermostat(item_type it);
      result_type  r;
      logic        ok;
      logic        held;
      int          t1;
      int          t2;
      logic [31:0] elapsed;
      logic [31:0] in_defrost;
      logic [31:0] left;
      ok = 1'b1;
      held = 1'b0;
      t1 = int'($signed(it.probe_one_temp));
      t2 = int'($signed(it.probe_two_temp));
      if (it.command == CMD_FORCE) begin
         defrost_pending = 1'b1;
         last_defrost_at = it.now_seconds - {12'd0, cfg_interval};
      end else begin
         elapsed = it.now_seconds - last_defrost_at;
         if (elapsed >= {12'd0, cfg_interval}) defrost_pending = 1'b1;
         if (ctl_mode == MODE_DEFROST) begin
            in_defrost = it.now_seconds - defrost_began_at;
            if (it.probe_two_valid && t2 >= cfg_stop_temp) begin
               close_defrost(it.now_seconds);
               defrost_cuts++;
            end else if (in_defrost >= {20'd0, cfg_max_time}) begin
               close_defrost(it.now_seconds);
            end
            held = 1'b1;
         end else if (defrost_pending && it.probe_two_valid) begin
            if (t2 <= cfg_start_th) begin
               ctl_mode = MODE_DEFROST;
               heat_active = 1'b1;
               comp_on = 1'b0;
               defrost_began_at = it.now_seconds;
               defrost_starts++;
               held = 1'b1;
            end else begin
               // evaporator too warm, skip this defrost and restart the interval
               defrost_pending = 1'b0;
               last_defrost_at = it.now_seconds;
            end
         end
         if (!held) begin
            if (!it.probe_one_valid) begin
               if (comp_on) begin
                  comp_on = 1'b0;
                  ctl_mode = MODE_IDLE;
               end
               ok = 1'b0;
            end else if (t1 > cfg_setpoint + cfg_hysteresis) begin
               if (!comp_on) begin
                  comp_on = 1'b1;
                  ctl_mode = MODE_COOLING;
                  cooling_starts++;
               end
            end else if (t1 < cfg_setpoint) begin
               if (comp_on) begin
                  comp_on = 1'b0;
                  ctl_mode = MODE_WAITING;
               end
            end
         end
      end
      elapsed = it.now_seconds - last_defrost_at;
      left = (elapsed >= {12'd0, cfg_interval}) ? 32'd0 : {12'd0, cfg_interval} - elapsed;
      r.compressor_drive   = (ctl_mode == MODE_DEFROST) ? 1'b0 : comp_on;
      r.heater_drive       = heat_active;
      r.mode               = ctl_mode;
      r.update_ok          = ok;
      r.seconds_to_defrost = left[19:0];
      r.cooling_count      = cooling_starts;
      r.defrost_count      = defrost_starts;
      r.defrost_cut_count  = defrost_cuts;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         mismatch_count++;
      end
   endfunction

   function automatic logic [15:0] clamp16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_readouts.push_back(step_thermostat(offered_item));
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item = pending_items.pop_front();
               req_command         <= offered_item.command;
               req_now_seconds     <= offered_item.now_seconds;
               req_probe_one_temp  <= offered_item.probe_one_temp;
               req_probe_two_temp  <= offered_item.probe_two_temp;
               req_probe_one_valid <= offered_item.probe_one_valid;
               req_probe_two_valid <= offered_item.probe_two_valid;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readouts.size() == 0) begin
               $error("result with no item outstanding");
               mismatch_count++;
            end else begin
               exp = expected_readouts.pop_front();
               check_field("compressor_drive", exp.compressor_drive, rsp_compressor_drive);
               check_field("heater_drive", exp.heater_drive, rsp_heater_drive);
               check_field("mode", exp.mode, rsp_mode);
               check_field("update_ok", exp.update_ok, rsp_update_ok);
               check_field("seconds_to_defrost", exp.seconds_to_defrost,
                           rsp_seconds_to_defrost);
               check_field("cooling_count", exp.cooling_count, rsp_cooling_count);
               check_field("defrost_count", exp.defrost_count, rsp_defrost_count);
               check_field("defrost_cut_count", exp.defrost_cut_count, rsp_defrost_cut_count);
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("thermostat_defrost_controller verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [8:0] h;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SETPOINT:   cfg_setpoint = int'($signed(value[15:0]));
         REG_HYSTERESIS: begin
            h = value[8:0];
            if (h < HYST_MIN) h = HYST_MIN;
            else if (h > HYST_MAX) h = HYST_MAX;
            cfg_hysteresis = int'(h);
         end
         REG_INTERVAL:   cfg_interval = value[19:0];
         REG_START_TH:   cfg_start_th = int'($signed(value[15:0]));
         REG_STOP_TEMP:  cfg_stop_temp = int'($signed(value[15:0]));
         REG_MAX_TIME:   cfg_max_time = value[11:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_SETPOINT, {{16{c.setpoint[15]}}, c.setpoint});
      write_reg(REG_HYSTERESIS, {23'd0, c.hysteresis});
      write_reg(REG_INTERVAL, {12'd0, c.defrost_interval_seconds});
      write_reg(REG_START_TH, {{16{c.defrost_start_threshold[15]}}, c.defrost_start_threshold});
      write_reg(REG_STOP_TEMP, {{16{c.defrost_stop_temperature[15]}},
                                c.defrost_stop_temperature});
      write_reg(REG_MAX_TIME, {20'd0, c.defrost_max_seconds});
      @(negedge clock);
   endtask

   task automatic add_sample(input logic [31:0] now, input int t1, input int t2,
                             input logic v1, input logic v2);
      item_type it;
      it.command = CMD_SAMPLE;
      it.now_seconds = now;
      it.probe_one_temp = clamp16(t1);
      it.probe_two_temp = clamp16(t2);
      it.probe_one_valid = v1;
      it.probe_two_valid = v2;
      pending_items.push_back(it);
   endtask

   task automatic add_force(input logic [31:0] now);
      item_type it;
      it.command = CMD_FORCE;
      it.now_seconds = now;
      it.probe_one_temp = 16'($urandom);
      it.probe_two_temp = 16'($urandom);
      it.probe_one_valid = 1'($urandom);
      it.probe_two_valid = 1'($urandom);
      pending_items.push_back(it);
   endtask

   // mostly plausible sample streams around the configured temperatures,
   // with forced defrosts, time jumps and raw noise mixed in
   task automatic queue_random_items(input int count, input int step_max);
      item_type it;
      int       pick;
      int       span;
      int       base;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            it.command = 1'($urandom);
            it.now_seconds = $urandom;
            it.probe_one_temp = 16'($urandom);
            it.probe_two_temp = 16'($urandom);
            it.probe_one_valid = 1'($urandom);
            it.probe_two_valid = 1'($urandom);
            sim_now = it.now_seconds;
            pending_items.push_back(it);
         end else if (pick < 16) begin
            sim_now += $urandom_range(step_max);
            add_force(sim_now);
         end else begin
            if (pick < 22) sim_now = $urandom;
            else sim_now += $urandom_range(step_max);
            span = cfg_hysteresis + 300;
            base = $urandom_range(1) ? cfg_start_th : cfg_stop_temp;
            add_sample(sim_now, cfg_setpoint - span + int'($urandom_range(2 * span)),
                       base - 300 + int'($urandom_range(600)),
                       $urandom_range(99) < 92, $urandom_range(99) < 92);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_readouts.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: thermostat edges, invalid probes, each defrost exit
      add_sample(32'd10, 32767, 0, 1'b1, 1'b1);
      add_sample(32'd20, -32768, 0, 1'b1, 1'b1);
      add_sample(32'd30, 500, 0, 1'b1, 1'b1);
      add_sample(32'd40, 500, 0, 1'b0, 1'b1);
      add_sample(32'd50, 0, 0, 1'b0, 1'b0);
      add_force(32'd1000);
      add_sample(32'd1001, 100, -32768, 1'b1, 1'b1);
      add_sample(32'd1002, 0, -5000, 1'b0, 1'b0);
      add_sample(32'd1010, 0, 32767, 1'b1, 1'b1);
      add_force(32'd2000);
      add_sample(32'd2001, 300, 32767, 1'b1, 1'b1);
      add_force(32'd3000);
      add_sample(32'd3001, 0, 0, 1'b1, 1'b0);
      add_sample(32'd3002, 0, -1200, 1'b1, 1'b1);
      add_sample(32'd3302, 0, -1, 1'b1, 1'b1);
      add_sample(32'hFFFF_FFFF, 32767, 32767, 1'b1, 1'b1);
      add_sample(32'd5, 0, 0, 1'b1, 1'b1);
      add_sample(32'd10, 200, 0, 1'b1, 1'b1);
      add_sample(32'd11, 199, 0, 1'b1, 1'b1);
      add_force(32'h8000_0000);
      wait_drained();

      // hysteresis below range clamps up, short interval
      apply_settings('{16'd400, 9'd0, 20'd120, 16'hFE0C, 16'd300, 12'd40});
      queue_random_items(300, 8);
      wait_drained();

      // hysteresis above range clamps down, sender idle
      send_idle_pct = 64;
      apply_settings('{16'hF8F8, 9'd511, 20'd600, 16'hF830, 16'd500, 12'd120});
      queue_random_items(300, 20);
      wait_drained();

      // zero interval and zero duration, receiver stalls
      send_idle_pct = 0;
      stall_pct = 64;
      apply_settings('{16'd0, 9'd200, 20'd0, 16'h7FFF, 16'h8000, 12'd0});
      add_sample(32'd100, 0, 0, 1'b1, 1'b1);
      add_sample(32'd100, 0, 0, 1'b1, 1'b0);
      add_sample(32'd101, 0, 0, 1'b1, 1'b1);
      add_sample(32'd102, 0, -32768, 1'b1, 1'b1);
      sim_now = 32'd200;
      queue_random_items(200, 5);
      wait_drained();

      // upper extremes, both sides idle
      send_idle_pct = 22;
      stall_pct = 22;
      apply_settings('{16'h7FFF, 9'd10, 20'hFFFFF, 16'h8000, 16'h7FFF, 12'd4095});
      queue_random_items(200, 3000);
      wait_drained();

      // lowest setpoint, long receiver hold while the sender keeps offering
      send_idle_pct = 0;
      stall_pct = 0;
      apply_settings('{16'h8000, 9'd300, 20'd90, 16'hFC18, 16'd0, 12'd20});
      hold_request = 1'b1;
      queue_random_items(300, 6);
      wait_drained();

      if (mismatch_count == 0)
         $display("thermostat_defrost_controller verification clean");
      else
         $display("thermostat_defrost_controller verification failed");
      $finish;
   end

endmodule
